[rtl/pdm_pkg.sv]
// Package for the palette row de-duplicating merger.
// Holds the fixed field widths, the engine state encoding and the structs that
// pass between the row gatherer, the search engine and the top level.
package pdm_pkg;

  // Configuration register width and its value after reset.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd16;

  // Result field widths.
  localparam int IDX_W   = 8;
  localparam int TOTAL_W = 9;

  // Engine states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WRITE  = 4'b0100,
    S_RESULT = 4'b1000
  } eng_state_t;

  // A row has just been completed by the gatherer.
  typedef struct packed {
    logic done;
    logic mode;
  } row_evt_t;

  // One result beat.
  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic               added;
    logic [TOTAL_W-1:0] row_total;
    logic               table_full;
  } res_t;

endpackage

[rtl/pdm_rowbuf.sv]
// Row gatherer: column counter, row mode and the row buffer memory.
// Depends on pdm_pkg for the row event struct and the configuration width.
module pdm_rowbuf #(
  parameter int MAX_WIDTH  = 16,
  parameter int PIXEL_BITS = 32,
  parameter int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  logic                     in_mode,
  input  logic [PIXEL_BITS-1:0]    in_pixel,
  input  logic [pdm_pkg::CFG_W-1:0] width,
  output pdm_pkg::row_evt_t        evt,
  input  logic [CW-1:0]            raddr,
  output logic [PIXEL_BITS-1:0]    rdata
);
  import pdm_pkg::*;

  localparam int KW = (CW + 2 > 6) ? CW + 2 : 6;

  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] q_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic                  mode_r, mode_nxt;
  logic                  last_col;

  // The row is complete once the gathered count reaches the current width.
  assign last_col = (KW'(col_r) + KW'(1)) >= KW'(width);
  assign evt.done = acc && last_col;
  assign evt.mode = (col_r == '0) ? in_mode : mode_r;

  always_comb begin
    col_nxt  = col_r;
    mode_nxt = mode_r;
    if (acc) begin
      if (col_r == '0) begin
        mode_nxt = in_mode;
      end
      col_nxt = last_col ? '0 : col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      mode_r <= mode_nxt;
    end
  end

  // Row buffer: one write port for incoming pixels, one registered read port.
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[col_r] <= in_pixel;
    end
    q_r <= mem[raddr];
  end

  assign rdata = q_r;

endmodule

[rtl/pdm_engine.sv]
// Search and append engine with the palette store memory.
// Depends on pdm_pkg for the state encoding, row event and result structs.
module pdm_engine #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_WIDTH  = 16,
  parameter int PIXEL_BITS = 32,
  parameter int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pdm_pkg::row_evt_t         evt,
  input  logic [pdm_pkg::CFG_W-1:0] width,
  output logic [CW-1:0]             rb_raddr,
  input  logic [PIXEL_BITS-1:0]     rb_q,
  output logic                      idle,
  output logic                      res_valid,
  output pdm_pkg::res_t             res,
  input  logic                      res_take
);
  import pdm_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int KW    = (CW + 2 > 6) ? CW + 2 : 6;

  eng_state_t            state_r, state_nxt;
  logic [RW-1:0]         rows_r, rows_nxt;
  logic [AW-1:0]         nbase_r, nbase_nxt;
  logic [AW-1:0]         sbase_r, sbase_nxt;
  logic [RW-1:0]         srow_r, srow_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic                  match_r, match_nxt;
  logic                  wr_done_r, wr_done_nxt;
  logic                  p_v_r, p_v_nxt;
  logic                  p_last_r, p_last_nxt;
  logic                  p_keep_r, p_keep_nxt;
  logic [RW-1:0]         p_row_r, p_row_nxt;
  logic [AW-1:0]         p_addr_r, p_addr_nxt;
  res_t                  res_r, res_nxt;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] st_q_r;
  logic [AW-1:0]         st_raddr;
  logic                  st_we;
  logic [PIXEL_BITS-1:0] st_wdata;
  logic                  issuing;
  logic                  row_match;
  logic                  can_add;
  logic                  go_append;

  assign st_raddr  = sbase_r + AW'(col_r);
  assign rb_raddr  = col_r;
  assign issuing   = (srow_r != rows_r);
  assign row_match = match_r && (st_q_r == rb_q);
  assign can_add   = (rows_r != RW'(MAX_ROWS));

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

  // Sequencer: a read is issued each cycle and its data compared or written
  // back in the next cycle, so each step works on the previous step's reads.
  always_comb begin
    state_nxt   = state_r;
    rows_nxt    = rows_r;
    nbase_nxt   = nbase_r;
    sbase_nxt   = sbase_r;
    srow_nxt    = srow_r;
    col_nxt     = col_r;
    match_nxt   = match_r;
    wr_done_nxt = wr_done_r;
    p_v_nxt     = 1'b0;
    p_last_nxt  = p_last_r;
    p_keep_nxt  = p_keep_r;
    p_row_nxt   = p_row_r;
    p_addr_nxt  = p_addr_r;
    res_nxt     = res_r;
    st_we       = 1'b0;
    st_wdata    = '0;
    go_append   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (evt.done) begin
          if (evt.mode) begin
            state_nxt = S_SCAN;
            srow_nxt  = '0;
            sbase_nxt = '0;
            col_nxt   = '0;
            match_nxt = 1'b1;
          end else begin
            go_append = 1'b1;
          end
        end
      end

      S_SCAN: begin
        // Issue the next pixel pair of the row under test.
        if (issuing) begin
          p_v_nxt    = 1'b1;
          p_last_nxt = (KW'(col_r) == (KW'(width) - KW'(1)));
          p_row_nxt  = srow_r;
          if (p_last_nxt) begin
            col_nxt   = '0;
            srow_nxt  = srow_r + RW'(1);
            sbase_nxt = sbase_r + AW'(MAX_WIDTH);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
        // Compare the pair read in the previous cycle.
        if (p_v_r) begin
          match_nxt = p_last_r ? 1'b1 : row_match;
        end
        if (p_v_r && p_last_r && row_match) begin
          state_nxt = S_RESULT;
          res_nxt   = '{row_index: IDX_W'(p_row_r), added: 1'b0,
                        row_total: TOTAL_W'(rows_r), table_full: 1'b0};
        end else if (!issuing && !p_v_r) begin
          go_append = 1'b1;
        end
      end

      S_WRITE: begin
        // Read the row buffer slot by slot; slots beyond the width store zero.
        if (!wr_done_r) begin
          p_v_nxt    = 1'b1;
          p_last_nxt = (KW'(col_r) == KW'(MAX_WIDTH - 1));
          p_keep_nxt = (KW'(col_r) < KW'(width));
          p_addr_nxt = nbase_r + AW'(col_r);
          if (p_last_nxt) begin
            wr_done_nxt = 1'b1;
            col_nxt     = '0;
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
        if (p_v_r) begin
          st_we    = 1'b1;
          st_wdata = p_keep_r ? rb_q : '0;
          if (p_last_r) begin
            rows_nxt  = rows_r + RW'(1);
            nbase_nxt = nbase_r + AW'(MAX_WIDTH);
            state_nxt = S_RESULT;
            res_nxt   = '{row_index: IDX_W'(rows_r), added: 1'b1,
                          row_total: TOTAL_W'(rows_r + RW'(1)), table_full: 1'b0};
          end
        end
      end

      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // No match, or append mode: store the row if there is room.
    if (go_append) begin
      if (can_add) begin
        state_nxt   = S_WRITE;
        col_nxt     = '0;
        wr_done_nxt = 1'b0;
      end else begin
        state_nxt = S_RESULT;
        res_nxt   = '{row_index: '0, added: 1'b0,
                      row_total: TOTAL_W'(rows_r), table_full: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rows_r    <= '0;
      nbase_r   <= '0;
      sbase_r   <= '0;
      srow_r    <= '0;
      col_r     <= '0;
      match_r   <= 1'b1;
      wr_done_r <= 1'b0;
      p_v_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rows_r    <= rows_nxt;
      nbase_r   <= nbase_nxt;
      sbase_r   <= sbase_nxt;
      srow_r    <= srow_nxt;
      col_r     <= col_nxt;
      match_r   <= match_nxt;
      wr_done_r <= wr_done_nxt;
      p_v_r     <= p_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_last_r <= p_last_nxt;
    p_keep_r <= p_keep_nxt;
    p_row_r  <= p_row_nxt;
    p_addr_r <= p_addr_nxt;
    res_r    <= res_nxt;
  end

  // Palette store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (st_we) begin
      mem[p_addr_r] <= st_wdata;
    end
    st_q_r <= mem[st_raddr];
  end

  // The store is written only while a row is being appended.
  a_write_only_in_append: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_WRITE))
    else $error("palette store written outside an append");

  // The row count moves only on leaving an append.
  a_rows_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WRITE) |=> (rows_r == $past(rows_r)))
    else $error("row count changed outside an append");

  // An appended row is the last one counted.
  a_added_total: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.added) |-> (res_r.row_total == TOTAL_W'(rows_r)))
    else $error("appended row does not match the row count");

  // A dropped row is only reported when the table is full.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.table_full) |-> (rows_r == RW'(MAX_ROWS) && !res_r.added))
    else $error("table full reported with room left");

endmodule

[rtl/palette_row_dedup_merge.sv]
// Top level of the palette row de-duplicating merger.
// Instantiates pdm_rowbuf and pdm_engine; depends on pdm_pkg.
//
// Usage:
//   Pixels enter on the in_ channel, one per beat, with in_mode taken from the
//   first pixel of each row. After palette_width pixels the row is complete.
//   In merge mode the row is compared with every stored row, lowest first, and
//   a match gives that row's index; otherwise, and always in append mode, the
//   row is stored. One result beat leaves on the out_ channel per row.
//   cfg_data sets palette_width (0 acts as 1, values above MAX_WIDTH clamp).
// Timing:
//   Pixels that do not complete a row are taken every cycle while the engine is
//   idle. A completing pixel holds in_ready low while the row is handled, one
//   memory access per cycle: a merge scan reads the stored rows up to the match,
//   and an append covers all MAX_WIDTH slots, since every slot of the new row
//   is written through the single store write port. A table-full drop stores
//   nothing. The result then waits in the engine for the output register,
//   which frees it as soon as that register is empty or taken.
// Reset clears the row count, the column count and the width (to 16); the
// memories are not cleared. A stalled receiver holds the output beat and,
// once the engine has its next result, also the input channel.
module palette_row_dedup_merge #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_WIDTH  = 16,
  parameter int PIXEL_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [PIXEL_BITS-1:0]        in_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pdm_pkg::IDX_W-1:0]    out_row_index,
  output logic                         out_added,
  output logic [pdm_pkg::TOTAL_W-1:0]  out_row_total,
  output logic                         out_table_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pdm_pkg::CFG_W-1:0]    cfg_data
);
  import pdm_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = 10;

  logic [CFG_W-1:0]      width_r, width_nxt;
  logic [CFG_W-1:0]      eff_width;
  logic                  in_acc;
  row_evt_t              evt;
  logic [CW-1:0]         rb_raddr;
  logic [PIXEL_BITS-1:0] rb_q;
  logic                  eng_idle;
  logic                  res_valid;
  res_t                  res;
  logic                  res_take;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_r;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;
  assign width_nxt = (cfg_valid && cfg_ready) ? cfg_data : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else begin
      width_r <= width_nxt;
    end
  end

  // Width in force: zero acts as one, larger than the buffer clamps.
  always_comb begin
    priority if (width_r == '0) begin
      eff_width = CFG_W'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      eff_width = CFG_W'(MAX_WIDTH);
    end else begin
      eff_width = width_r;
    end
  end

  assign in_ready = eng_idle;
  assign in_acc   = in_valid && in_ready;

  pdm_rowbuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW)
  ) u_rowbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_mode  (in_mode),
    .in_pixel (in_pixel),
    .width    (eff_width),
    .evt      (evt),
    .raddr    (rb_raddr),
    .rdata    (rb_q)
  );

  pdm_engine #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .width     (eff_width),
    .rb_raddr  (rb_raddr),
    .rb_q      (rb_q),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: loads a result beat when empty or being emptied.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    priority if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_r.row_index;
  assign out_added      = out_r.added;
  assign out_row_total  = out_r.row_total;
  assign out_table_full = out_r.table_full;

endmodule

[dv/palette_row_dedup_merge_tb.sv]
// Self-checking testbench for the palette row de-duplicating merger.
// Predicts every row result in a small scoreboard class, drives the pixel and
// result channels with random gaps, writes widths; depends on pdm_pkg and the RTL.
module palette_row_dedup_merge_tb;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_WIDTH  = 16;
  localparam int PIXEL_BITS = 32;

  // Row modes as carried by the first pixel of a row.
  localparam bit MODE_APPEND = 1'b0;
  localparam bit MODE_MERGE  = 1'b1;

  // Predicts the result of every completed row and checks the result beats.
  class row_result_board;
    logic [PIXEL_BITS-1:0] palette [MAX_ROWS][MAX_WIDTH];
    logic [PIXEL_BITS-1:0] gathered [MAX_WIDTH];
    int unsigned           rows_held;
    int unsigned           column;
    logic [pdm_pkg::CFG_W-1:0] width_reg;
    bit                    row_is_merge;
    pdm_pkg::res_t         pending_rows[$];
    int unsigned           failures;
    int unsigned           reported;
    int unsigned           hits;
    int unsigned           appends;
    int unsigned           drops;

    function new();
      rows_held    = 0;
      column       = 0;
      width_reg    = pdm_pkg::WIDTH_RESET;
      row_is_merge = 1'b0;
      failures     = 0;
      reported     = 0;
      hits         = 0;
      appends      = 0;
      drops        = 0;
    endfunction

    // A width of zero acts as one; anything above the row size is clamped.
    function int unsigned live_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    // Gathers one accepted pixel and, when the row completes, works out its result.
    function void note_pixel(bit mode, logic [PIXEL_BITS-1:0] pix);
      int unsigned   w;
      int unsigned   r;
      int unsigned   c;
      bit            found;
      bit            same;
      pdm_pkg::res_t res;
      w = live_width();
      if (column == 0) row_is_merge = (mode == MODE_MERGE);
      if (column < MAX_WIDTH) gathered[column] = pix;
      column++;
      if (column < w) return;
      column = 0;
      found  = 1'b0;
      res    = '0;
      // Merge mode searches the stored rows, lowest index first.
      if (row_is_merge) begin
        for (r = 0; r < rows_held && !found; r++) begin
          same = 1'b1;
          for (c = 0; c < w; c++) begin
            if (palette[r][c] !== gathered[c]) same = 1'b0;
          end
          if (same) begin
            found = 1'b1;
            res.row_index = r[pdm_pkg::IDX_W-1:0];
          end
        end
      end
      if (found) begin
        hits++;
      end else if (rows_held >= MAX_ROWS) begin
        res.table_full = 1'b1;
        drops++;
      end else begin
        // Slots beyond the width in force are stored as zero.
        for (c = 0; c < MAX_WIDTH; c++) begin
          palette[rows_held][c] = (c < w) ? gathered[c] : '0;
        end
        res.row_index = rows_held[pdm_pkg::IDX_W-1:0];
        res.added     = 1'b1;
        rows_held++;
        appends++;
      end
      res.row_total = rows_held[pdm_pkg::TOTAL_W-1:0];
      pending_rows.push_back(res);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_row_result(pdm_pkg::res_t got);
      pdm_pkg::res_t want;
      if (pending_rows.size() == 0) begin
        failures++;
        reported++;
        if (reported <= 10)
          $display("Unexpected row result: index %0d added %0b total %0d full %0b",
                   got.row_index, got.added, got.row_total, got.table_full);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index || got.added !== want.added ||
          got.row_total !== want.row_total || got.table_full !== want.table_full) begin
        failures++;
        reported++;
        if (reported <= 10)
          $display("Row result mismatch: expected index %0d added %0b total %0d full %0b, %s",
                   want.row_index, want.added, want.row_total, want.table_full,
                   $sformatf("got index %0d added %0b total %0d full %0b",
                             got.row_index, got.added, got.row_total, got.table_full));
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_mode = 1'b0;
  logic [PIXEL_BITS-1:0]         in_pixel = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pdm_pkg::IDX_W-1:0]     out_row_index;
  logic                          out_added;
  logic [pdm_pkg::TOTAL_W-1:0]   out_row_total;
  logic                          out_table_full;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pdm_pkg::CFG_W-1:0]     cfg_data = '0;

  row_result_board board = new();
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int holdoff_left  = 0;
  int widths_written = 0;

  palette_row_dedup_merge #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_added      (out_added),
    .out_row_total  (out_row_total),
    .out_table_full (out_table_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Free-running clock, period 10.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: checks each beat and stalls at random or for a long hold-off.
  initial begin
    pdm_pkg::res_t seen;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        seen.row_index  = out_row_index;
        seen.added      = out_added;
        seen.row_total  = out_row_total;
        seen.table_full = out_table_full;
        board.check_row_result(seen);
      end
      if (holdoff_left > 0) begin
        out_ready <= 1'b0;
        holdoff_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  // Offers one pixel beat, waits for it to be taken, then idles at random.
  task automatic send_pixel(input bit mode, input logic [PIXEL_BITS-1:0] pix);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(mode, pix);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
  endtask

  // Waits until every predicted row has come back and the block has settled.
  task automatic drain_rows();
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the row width through the configuration channel.
  task automatic write_width(input logic [pdm_pkg::CFG_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.width_reg = w;
    widths_written++;
  endtask

  // Sets how often the sender idles and the receiver stalls.
  task automatic set_idling(input int sel);
    case (sel % 4)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 58; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 58; end
      default: begin in_idle_pct = 21; out_stall_pct = 21; end
    endcase
  endtask

  // Random rows: mostly copies of stored rows to hit the search, some fresh.
  task automatic send_random_rows(input int count);
    logic [PIXEL_BITS-1:0] pool [4];
    logic [PIXEL_BITS-1:0] pix;
    bit                    mode;
    bit                    row_merge;
    int                    target;
    int                    n;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h8000_0001;
    pool[3] = 32'h7F3C_C3FE;
    target = -1;
    for (n = 0; n < count; n++) begin
      if (board.column == 0) begin
        row_merge = ($urandom_range(0, 99) < 60);
        mode      = row_merge ? MODE_MERGE : MODE_APPEND;
        if (board.rows_held > 0 && $urandom_range(0, 99) < 55)
          target = $urandom_range(0, board.rows_held - 1);
        else
          target = -1;
      end else begin
        // Only the first pixel's mode counts, so the rest carry noise.
        mode = 1'($urandom_range(0, 1));
      end
      if (target >= 0) begin
        pix = board.palette[target][board.column];
        if ($urandom_range(0, 99) < 8) pix ^= 32'(1) << $urandom_range(0, 31);
      end else begin
        case ($urandom_range(0, 3))
          0:       pix = pool[$urandom_range(0, 3)];
          1:       pix = pool[$urandom_range(0, 1)];
          default: pix = $urandom();
        endcase
      end
      send_pixel(mode, pix);
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    logic [pdm_pkg::CFG_W-1:0] phase_width [8];
    int p;
    phase_width = '{5'd4, 5'd16, 5'd2, 5'd7, 5'd31, 5'd3, 5'd0, 5'd1};
    phase_width[3] = 5'($urandom_range(5, 9));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Width zero acts as one: append, match, fresh merge, its match, repeat in append mode.
    write_width(5'd0);
    send_pixel(MODE_APPEND, 32'h0000_0000);
    send_pixel(MODE_MERGE,  32'h0000_0000);
    send_pixel(MODE_MERGE,  32'hFFFF_FFFF);
    send_pixel(MODE_MERGE,  32'hFFFF_FFFF);
    send_pixel(MODE_APPEND, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    drain_rows();

    // Width above the maximum, then narrowed mid-row: the row ends at once
    // and matches against the zero-filled tail of a narrow stored row.
    write_width(5'd31);
    send_pixel(MODE_MERGE,  32'h0000_0000);
    send_pixel(MODE_APPEND, 32'h0000_0000);
    send_pixel(MODE_APPEND, 32'h1234_5678);
    in_valid <= 1'b0;
    drain_rows();
    write_width(5'd2);
    send_pixel(MODE_MERGE,  32'h0BAD_F00D);
    send_pixel(MODE_MERGE,  32'hFFFF_FFFF);
    send_pixel(MODE_APPEND, 32'h0000_0000);
    send_pixel(MODE_APPEND, 32'hA5A5_A5A5);
    send_pixel(MODE_MERGE,  32'h5A5A_5A5A);
    in_valid <= 1'b0;
    drain_rows();

    // Wider than the stored row: the extra column must match its zero fill.
    write_width(5'd3);
    send_pixel(MODE_MERGE, 32'hA5A5_A5A5);
    send_pixel(MODE_MERGE, 32'h5A5A_5A5A);
    send_pixel(MODE_MERGE, 32'h0000_0000);
    in_valid <= 1'b0;

    // Random phases; each may end mid-row so the next width lands mid-row.
    for (p = 0; p < 8; p++) begin
      drain_rows();
      write_width(phase_width[p]);
      set_idling(p);
      if (p == 7) begin
        // Long receiver hold-off with a busy sender, so the input backs up.
        in_idle_pct  = 0;
        holdoff_left = 1500;
      end
      send_random_rows(170 + $urandom_range(0, 10));
    end

    // Fill the store, then drop rows in both modes and still find matches.
    drain_rows();
    write_width(5'd1);
    set_idling(3);
    while (board.rows_held < MAX_ROWS) send_pixel(MODE_APPEND, $urandom());
    send_pixel(MODE_APPEND, 32'h0000_0000);
    send_pixel(MODE_MERGE,  $urandom());
    send_pixel(MODE_MERGE,  board.palette[MAX_ROWS-1][0]);
    send_pixel(MODE_MERGE,  board.palette[0][0]);
    in_valid <= 1'b0;

    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    board.failures += board.pending_rows.size();

    $display("Rows handled over %0d width settings: %0d stored, %0d matched, %0d dropped.",
             widths_written, board.appends, board.hits, board.drops);
    $display("Result beats that failed their check: %0d.", board.failures);
    if (board.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pdm_pkg.sv
rtl/pdm_rowbuf.sv
rtl/pdm_engine.sv
rtl/palette_row_dedup_merge.sv
dv/palette_row_dedup_merge_tb.sv
